// ----- hw/rtl/brs_pkg.sv -----
`timescale 1ns / 1ps
// brs_pkg: shared types and constants of the 2x block resampler.
// Used by brs_front, brs_expand and block_resample_2x_top.
package brs_pkg;

  localparam int SampleW   = 16;
  localparam int PosW      = 5;
  localparam int OutPosW   = 6;
  localparam int PairW     = 17;
  localparam int SlotW     = 4;
  localparam int StoreDepth = 16;
  localparam int DimW      = 3;
  localparam int TdataW    = 32;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 3;

  localparam logic [CfgIdxW-1:0] RegModeGrow = 1'd0;
  localparam logic [CfgIdxW-1:0] RegDimLog2  = 1'd1;

  localparam logic [DimW-1:0] DimMin = 3'd1;
  localparam logic [DimW-1:0] DimMax = 3'd5;

  // one result record handed from the front end to the output sequencer
  typedef struct packed {
    logic [SampleW-1:0] value;
    logic [OutPosW-1:0] row;
    logic [OutPosW-1:0] col;
    logic               last;
    logic               grow;
  } res_t;

  // position mask (side - 1) for a block side of 2^dim_log2, clamped to 1..5
  function automatic logic [PosW-1:0] side_mask(input logic [DimW-1:0] lg);
    logic [DimW-1:0] l;
    l = lg;
    if (lg < DimMin) begin
      l = DimMin;
    end else if (lg > DimMax) begin
      l = DimMax;
    end
    side_mask = PosW'((6'd1 << l) - 6'd1);
  endfunction

endpackage

// ----- hw/rtl/brs_front.sv -----
`timescale 1ns / 1ps
// brs_front: config registers, block position counters, input register,
// pair-sum accumulation and half-row line store. Depends on brs_pkg.
module brs_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [brs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [brs_pkg::CfgDataW-1:0] cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [brs_pkg::SampleW-1:0] s_tdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output brs_pkg::res_t            res
);
  import brs_pkg::*;

  logic              mode_grow;
  logic [DimW-1:0]   dim_log2;
  logic [PosW-1:0]   col_index;
  logic [PosW-1:0]   row_index;
  logic [PosW-1:0]   col_index_next;
  logic [PosW-1:0]   row_index_next;
  logic [PairW-1:0]  pair_sum;
  logic [PairW-1:0]  sum2;
  logic [PairW:0]    total;
  logic [PosW-1:0]   mask;
  logic              in_xfer;

  logic [PairW-1:0]  row_pair_store [StoreDepth];
  logic [PairW-1:0]  store_rd;

  logic               s1_valid;
  logic [SampleW-1:0] s1_sample;
  logic [PosW-1:0]    s1_row;
  logic [PosW-1:0]    s1_col;
  logic               s1_last;
  logic               s1_grow;
  logic               s1_emit;
  logic               s1_adv;

  assign mask    = side_mask(dim_log2);
  assign in_xfer = s_tvalid && s_tready;

  always_comb begin
    col_index_next = col_index + PosW'(1);
    row_index_next = row_index;
    if (col_index == mask) begin
      col_index_next = '0;
      row_index_next = (row_index == mask) ? '0 : row_index + PosW'(1);
    end
  end

  assign s1_emit  = s1_grow || (s1_col[0] && s1_row[0]);
  assign s1_adv   = s1_valid && (!s1_emit || res_ready);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_grow <= 1'b0;
      dim_log2  <= 3'd3;
      col_index <= '0;
      row_index <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegModeGrow: mode_grow <= cfg_data[0];
          RegDimLog2:  dim_log2  <= cfg_data;
          default: ;
        endcase
        col_index <= '0;
        row_index <= '0;
      end else if (in_xfer) begin
        col_index <= col_index_next;
        row_index <= row_index_next;
      end
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample <= s_tdata;
      s1_row    <= row_index;
      s1_col    <= col_index;
      s1_last   <= (row_index == mask) && (col_index == mask);
      s1_grow   <= mode_grow;
      store_rd  <= row_pair_store[col_index[PosW-1:1]];
    end
  end

  assign sum2  = pair_sum + PairW'(s1_sample);
  assign total = {1'b0, store_rd} + {1'b0, sum2};

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pair_sum <= '0;
    end else if (s1_adv && !s1_grow) begin
      pair_sum <= s1_col[0] ? sum2 : PairW'(s1_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_grow && s1_col[0] && !s1_row[0]) begin
      row_pair_store[s1_col[PosW-1:1]] <= sum2;
    end
  end

  assign res_valid = s1_valid && s1_emit;

  always_comb begin
    res.last = s1_last;
    res.grow = s1_grow;
    if (s1_grow) begin
      res.value = s1_sample;
      res.row   = {s1_row, 1'b0};
      res.col   = {s1_col, 1'b0};
    end else begin
      res.value = total[PairW:2];
      res.row   = OutPosW'(s1_row[PosW-1:1]);
      res.col   = OutPosW'(s1_col[PosW-1:1]);
    end
  end

endmodule

// ----- hw/rtl/brs_expand.sv -----
`timescale 1ns / 1ps
// brs_expand: output register and sequencer; one transfer per shrink record,
// four per grow record in 2x2 raster order. Depends on brs_pkg.
module brs_expand (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  output logic                        res_ready,
  input  brs_pkg::res_t               res,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [brs_pkg::TdataW-1:0]  m_tdata,  // value[15:0], out_row[21:16], out_col[27:22], 0
  output logic                        m_tlast   // end_of_block
);
  import brs_pkg::*;

  res_t        hold;
  logic        hold_valid;
  logic [1:0]  beat;
  logic        final_beat;
  logic        out_xfer;
  logic [OutPosW-1:0] row_out;
  logic [OutPosW-1:0] col_out;

  assign final_beat = !hold.grow || (beat == 2'd3);
  assign out_xfer   = hold_valid && m_tready;
  assign res_ready  = !hold_valid || (out_xfer && final_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      beat       <= 2'd0;
    end else begin
      if (res_valid && res_ready) begin
        hold_valid <= 1'b1;
        beat       <= 2'd0;
      end else if (out_xfer) begin
        if (final_beat) begin
          hold_valid <= 1'b0;
          beat       <= 2'd0;
        end else begin
          beat <= beat + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      hold <= res;
    end
  end

  assign row_out  = hold.row | OutPosW'(hold.grow & beat[1]);
  assign col_out  = hold.col | OutPosW'(hold.grow & beat[0]);
  assign m_tvalid = hold_valid;
  assign m_tdata  = TdataW'({col_out, row_out, hold.value});
  assign m_tlast  = hold.last && final_beat;

  a_beat_shrink: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !hold.grow |-> beat == 2'd0)
    else $error("beat counter moved on a shrink record");

  a_beat_hold: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !m_tready |=> hold_valid && $stable(beat))
    else $error("beat changed while output stalled");

  a_beat_step: assert property (@(posedge clk) disable iff (rst)
    out_xfer && hold.grow && beat != 2'd3 |=> hold_valid && beat == $past(beat) + 2'd1)
    else $error("grow sequence skipped a beat");

  a_take_only_free: assert property (@(posedge clk) disable iff (rst)
    res_ready && hold_valid |-> out_xfer && final_beat)
    else $error("record taken while previous one still pending");

endmodule

// ----- hw/rtl/block_resample_2x_top.sv -----
`timescale 1ns / 1ps
// block_resample_2x_top: 2x block resampler, shrink by 2x2 box average or
// grow by pixel replication. Depends on brs_pkg, brs_front, brs_expand.
//
// Usage:
//   Samples enter on s_tvalid/s_tready/s_tdata in raster order within square
//   blocks of side 2^dim_log2 (1..5), blocks back to back. Results leave on
//   m_tvalid/m_tready/m_tdata/m_tlast; m_tlast marks the block's final output.
//   Config writes (cfg_we, cfg_index, cfg_data) go in while idle; any write
//   restarts the block position.
// Path: a sample is registered in the input register of brs_front, then its
//   first result in the output register of brs_expand before it leaves on m_tdata.
// Throughput: shrink mode takes one sample per cycle while the output does not
//   stall (one result per four samples); grow mode emits four results per sample
//   over the one output port, so it takes samples at a quarter of the output rate.
// Reset: rst (synchronous) returns mode to shrink, dim_log2 to 3, position to
//   the block start and drops all pending results.
// Stall: with m_tready low the output holds; samples without a result pass on,
//   the next one with a result waits in the input register, after which
//   s_tready falls until the output drains.
module block_resample_2x_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [brs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [brs_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [brs_pkg::SampleW-1:0]   s_tdata,   // sample[15:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [brs_pkg::TdataW-1:0]    m_tdata,   // value[15:0], out_row[21:16], out_col[27:22], 0
  output logic                          m_tlast    // end_of_block
);
  import brs_pkg::*;

  res_t res;
  logic res_valid;
  logic res_ready;

  brs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  brs_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
